/* hdl/folv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// folv_pkg
// Widths, register indexes, sequencer states and saturation helpers for the
// variable-step first-order lag.
// ----------------------------------------------------------------------------
package folv_pkg;

    localparam int VW  = 32;   // value width, Q16.16
    localparam int TW  = 32;   // time stamp width
    localparam int T1W = 24;   // time constant width
    localparam int MW  = 34;   // multiplier operand width
    localparam int PW  = 2 * MW; // product width
    localparam int DW  = 32;   // divisor width
    localparam int QW  = 33;   // quotient magnitude width
    localparam int CW  = 6;    // divider step counter width
    localparam int LW  = 25;   // step length width
    localparam int KW  = 33;   // substep position width
    localparam int CIW = 2;    // config index width

    localparam logic [CIW-1:0] CFG_T1   = 2'd0;
    localparam logic [CIW-1:0] CFG_GAIN = 2'd1;
    localparam logic [CIW-1:0] CFG_BIAS = 2'd2;

    localparam logic signed [PW-1:0] VMAX_P = PW'({1'b0, {(VW-1){1'b1}}});
    localparam logic signed [PW-1:0] VMIN_P = -VMAX_P - PW'(1);
    localparam logic signed [PW-1:0] RND_HALF = PW'(32768);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_JMUL,
        ST_JSAT,
        ST_IMUL,
        ST_TMUL1,
        ST_TTGT,
        ST_TMUL2,
        ST_DIVLD,
        ST_DIV,
        ST_IUPD,
        ST_TUPD,
        ST_OUT
    } t_state;

    function automatic logic signed [VW-1:0] sat_v(input logic signed [PW-1:0] x);
        logic signed [VW-1:0] r;
        if (x > VMAX_P) begin
            r = VMAX_P[VW-1:0];
        end else if (x < VMIN_P) begin
            r = VMIN_P[VW-1:0];
        end else begin
            r = x[VW-1:0];
        end
        return r;
    endfunction

    // Q16.16 product: round to nearest (ties up), then saturate
    function automatic logic signed [VW-1:0] rnd_sat(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] t;
        t = (p + RND_HALF) >>> 16;
        return sat_v(t);
    endfunction

endpackage

/* hdl/folv_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// folv_in_if / folv_out_if
// Valid/ready channels for sample items and filtered result items.
// ----------------------------------------------------------------------------
interface folv_in_if import folv_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic signed [VW-1:0] sample;
    logic [TW-1:0]        time_stamp;

    modport source (output valid, output sample, output time_stamp, input ready);
    modport sink   (input valid, input sample, input time_stamp, output ready);
endinterface

interface folv_out_if import folv_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic signed [VW-1:0] filtered;

    modport source (output valid, output filtered, input ready);
    modport sink   (input valid, input filtered, output ready);
endinterface

/* hdl/first_order_lag_variable_step_core.sv */
`timescale 1ns / 1ps
// Update modes: jump or bypass; a single trapezoidal step; or n = ceil(20*dt/T1) - 1
// substeps (n <= 99) followed by a remainder step.
// Throughput: one item at a time; cost set by one shared 34x34 multiplier and a
// 33-step restoring divider used twice per substep.
// Reset (synchronous, active low): lag state, last input and last time cleared,
// T1 = 0, gain = 1.0, bias = 0, no result pending.
// ----------------------------------------------------------------------------
// first_order_lag_variable_step_core
// First-order lag K/(1+sT1) over variable time steps with a sequenced
// multiply/divide datapath.
// ----------------------------------------------------------------------------
module first_order_lag_variable_step_core import folv_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [CIW-1:0] i_cfg_idx,
    input  logic [VW-1:0]  i_cfg_data,
    folv_in_if.sink        i_in,
    folv_out_if.source     o_out
);

    t_state r_state, n_state;

    logic [T1W-1:0]       r_t1;
    logic signed [VW-1:0] r_gain, r_bias;
    logic signed [VW-1:0] r_lag, n_lag;
    logic signed [VW-1:0] r_last, n_last;
    logic [TW-1:0]        r_last_time, n_last_time;
    logic signed [VW-1:0] r_inp, n_inp;
    logic [TW-1:0]        r_now, n_now;
    logic [TW-1:0]        r_dt, n_dt;
    logic [DW-1:0]        r_dt20, n_dt20;
    logic signed [VW-1:0] r_a, n_a, r_b, n_b, r_prev, n_prev;
    logic [LW-1:0]        r_len, n_len;
    logic [KW-1:0]        r_kt1, n_kt1;
    logic                 r_final, n_final;
    logic                 r_div_trap, n_div_trap;
    logic signed [PW-1:0] r_prod, n_prod;
    logic signed [VW:0]   r_d, n_d;
    logic [DW-1:0]        r_rem, n_rem;
    logic [QW-1:0]        r_dq, n_dq;
    logic                 r_neg, n_neg;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [DW-1:0]        r_den, n_den;
    logic                 r_ovalid, n_ovalid;
    logic signed [VW-1:0] r_res, n_res;

    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] mag;
    logic [DW:0]          rem_sh;
    logic                 rem_ge;
    logic signed [MW-1:0] quot;
    logic signed [VW:0]   half_sum;
    logic [TW+4:0]        dt20_full;
    logic [DW-1:0]        t1x20;
    logic [TW-1:0]        t1x5;
    logic [KW-1:0]        kt1_nx;
    logic signed [MW-1:0] cur_sum;

    assign i_in.ready     = (r_state == ST_IDLE);
    assign o_out.valid    = r_ovalid;
    assign o_out.filtered = r_res;

    assign dt20_full = {r_dt, 4'b0} + {2'b0, r_dt, 2'b0};
    assign t1x20     = DW'({r_t1, 4'b0}) + DW'({r_t1, 2'b0});
    assign t1x5      = TW'({r_t1, 2'b0}) + TW'(r_t1);
    assign kt1_nx    = r_kt1 + KW'(r_t1);
    assign half_sum  = ((VW+1)'(r_a) + (VW+1)'(r_b)) >>> 1;
    assign mag       = r_prod[PW-1] ? -r_prod : r_prod;
    assign rem_sh    = {r_rem, r_dq[QW-1]};
    assign rem_ge    = rem_sh >= {1'b0, r_den};
    assign quot      = r_neg ? -$signed({1'b0, r_dq}) : $signed({1'b0, r_dq});
    assign cur_sum   = MW'(r_last) + quot;

    always_comb begin
        n_state     = r_state;
        n_lag       = r_lag;
        n_last      = r_last;
        n_last_time = r_last_time;
        n_inp       = r_inp;
        n_now       = r_now;
        n_dt        = r_dt;
        n_dt20      = r_dt20;
        n_a         = r_a;
        n_b         = r_b;
        n_prev      = r_prev;
        n_len       = r_len;
        n_kt1       = r_kt1;
        n_final     = r_final;
        n_div_trap  = r_div_trap;
        n_prod      = r_prod;
        n_d         = r_d;
        n_rem       = r_rem;
        n_dq        = r_dq;
        n_neg       = r_neg;
        n_cnt       = r_cnt;
        n_den       = r_den;
        n_ovalid    = r_ovalid && !o_out.ready;
        n_res       = r_res;
        mul_a       = '0;
        mul_b       = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_inp   = sat_v(PW'(i_in.sample) + PW'(r_bias));
                    n_now   = i_in.time_stamp;
                    n_dt    = i_in.time_stamp - r_last_time;
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_dt20 = dt20_full[DW-1:0];
                if (r_t1 == '0 || r_dt >= t1x5) begin
                    n_state = ST_JMUL;
                end else if (dt20_full <= (TW+5)'(r_t1)) begin
                    // one trapezoidal step over the whole interval
                    n_a     = r_inp;
                    n_b     = r_last;
                    n_len   = LW'(dt20_full);
                    n_final = 1'b1;
                    n_state = ST_TMUL1;
                end else begin
                    n_kt1   = KW'(r_t1);
                    n_prev  = r_last;
                    n_final = 1'b0;
                    n_state = ST_IMUL;
                end
            end
            ST_JMUL: begin
                mul_a   = MW'(r_gain);
                mul_b   = MW'(r_inp);
                n_prod  = mul_a * mul_b;
                n_state = ST_JSAT;
            end
            ST_JSAT: begin
                n_lag   = rnd_sat(r_prod);
                n_state = ST_OUT;
            end
            ST_IMUL: begin
                // interpolation numerator: (input - last) * k*T1
                mul_a      = MW'(r_inp) - MW'(r_last);
                mul_b      = $signed({1'b0, r_kt1});
                n_prod     = mul_a * mul_b;
                n_div_trap = 1'b0;
                n_state    = ST_DIVLD;
            end
            ST_TMUL1: begin
                mul_a   = MW'(r_gain);
                mul_b   = MW'(half_sum);
                n_prod  = mul_a * mul_b;
                n_state = ST_TTGT;
            end
            ST_TTGT: begin
                n_d     = (VW+1)'(rnd_sat(r_prod)) - (VW+1)'(r_lag);
                n_state = ST_TMUL2;
            end
            ST_TMUL2: begin
                mul_a      = MW'(r_d);
                mul_b      = $signed({(MW-LW)'(0), r_len});
                n_prod     = mul_a * mul_b;
                n_div_trap = 1'b1;
                n_state    = ST_DIVLD;
            end
            ST_DIVLD: begin
                n_rem   = mag[QW+DW-1:QW];
                n_dq    = mag[QW-1:0];
                n_neg   = r_prod[PW-1];
                n_cnt   = CW'(QW);
                n_den   = r_div_trap ? t1x20 : r_dt20;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_rem = rem_ge ? DW'(rem_sh - {1'b0, r_den}) : DW'(rem_sh);
                n_dq  = {r_dq[QW-2:0], rem_ge};
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_state = r_div_trap ? ST_TUPD : ST_IUPD;
                end
            end
            ST_IUPD: begin
                n_a     = r_prev;
                n_b     = cur_sum[VW-1:0];
                n_len   = LW'(r_t1);
                n_state = ST_TMUL1;
            end
            ST_TUPD: begin
                n_lag = sat_v(PW'(r_lag) + PW'(quot));
                if (r_final) begin
                    n_state = ST_OUT;
                end else if (kt1_nx < KW'(r_dt20)) begin
                    n_kt1   = kt1_nx;
                    n_prev  = r_b;
                    n_state = ST_IMUL;
                end else begin
                    // remainder step up to the new sample
                    n_a     = r_b;
                    n_b     = r_inp;
                    n_len   = LW'(KW'(r_dt20) - r_kt1);
                    n_final = 1'b1;
                    n_state = ST_TMUL1;
                end
            end
            ST_OUT: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid    = 1'b1;
                    n_res       = r_lag;
                    n_last      = r_inp;
                    n_last_time = r_now;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_t1        <= '0;
            r_gain      <= VW'(65536);
            r_bias      <= '0;
            r_lag       <= '0;
            r_last      <= '0;
            r_last_time <= '0;
            r_ovalid    <= 1'b0;
            r_final     <= 1'b0;
            r_div_trap  <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_lag       <= n_lag;
            r_last      <= n_last;
            r_last_time <= n_last_time;
            r_ovalid    <= n_ovalid;
            r_final     <= n_final;
            r_div_trap  <= n_div_trap;
            r_cnt       <= n_cnt;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_T1:   r_t1   <= i_cfg_data[T1W-1:0];
                    CFG_GAIN: r_gain <= i_cfg_data;
                    CFG_BIAS: r_bias <= i_cfg_data;
                    default:  ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_inp  <= n_inp;
        r_now  <= n_now;
        r_dt   <= n_dt;
        r_dt20 <= n_dt20;
        r_a    <= n_a;
        r_b    <= n_b;
        r_prev <= n_prev;
        r_len  <= n_len;
        r_kt1  <= n_kt1;
        r_prod <= n_prod;
        r_d    <= n_d;
        r_rem  <= n_rem;
        r_dq   <= n_dq;
        r_neg  <= n_neg;
        r_den  <= n_den;
        r_res  <= n_res;
    end

`ifndef ASSERT_OFF
    a_accept_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == ST_DECIDE))
        else $error("accepted item did not start the sequencer");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_cnt != '0))
        else $error("divider running with zero step count");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

    a_out_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && (!o_out.valid || o_out.ready))
        |=> (o_out.valid && r_state == ST_IDLE))
        else $error("result not issued when output was free");
`endif

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives timestamped samples into the variable-step lag under several gain,
// bias and time constant settings and checks every filtered item against a
// fixed-point lag predictor kept in step with the accepted samples.
// ----------------------------------------------------------------------------
module testbench;
    import folv_pkg::*;

    localparam longint VMAXL = 64'sd2147483647;
    localparam longint VMINL = -64'sd2147483648;
    localparam longint CYCLE_LIMIT = 64'd50000000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CIW-1:0] i_cfg_idx;
    logic [VW-1:0] i_cfg_data;

    folv_in_if  in_ch ();
    folv_out_if out_ch ();

    first_order_lag_variable_step_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    // predictor state and configuration
    longint lag_t1, lag_k, lag_bias, lag_v, lag_prev_in;
    longint unsigned lag_last_t;
    logic signed [VW-1:0] filtered_q[$];

    int mismatch_count;
    int result_count;
    longint cycle_count;
    bit send_stall_en;
    bit recv_stall_en;
    int hold_off_cycles;
    logic [TW-1:0] stamp_now;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint clamp_v(longint x);
        if (x > VMAXL) return VMAXL;
        if (x < VMINL) return VMINL;
        return x;
    endfunction

    function automatic longint q_mul(longint a, longint b);
        return clamp_v((a * b + 64'sd32768) >>> 16);
    endfunction

    function automatic longint trap_step(longint v, longint a, longint b,
                                         longint len, longint den);
        longint target;
        target = q_mul(lag_k, (a + b) >>> 1);
        return clamp_v(v + ((target - v) * len) / den);
    endfunction

    function automatic longint lag_update(logic signed [VW-1:0] smp, logic [TW-1:0] ts);
        longint x, dt, dt20, n, delta, v, prev_pt, cur;
        x = clamp_v(longint'(smp) + lag_bias);
        dt = longint'({32'd0, ts - lag_last_t[TW-1:0]});
        if (lag_t1 == 0 || dt >= 5 * lag_t1) begin
            lag_v = q_mul(lag_k, x);
        end else if (dt * 20 <= lag_t1) begin
            lag_v = trap_step(lag_v, x, lag_prev_in, dt * 20, 20 * lag_t1);
        end else begin
            dt20 = dt * 20;
            n = (dt20 - 1) / lag_t1;
            delta = x - lag_prev_in;
            v = lag_v;
            prev_pt = lag_prev_in;
            for (longint k = 1; k <= n; k++) begin
                cur = lag_prev_in + (delta * (k * lag_t1)) / dt20;
                v = trap_step(v, prev_pt, cur, lag_t1, 20 * lag_t1);
                prev_pt = cur;
            end
            lag_v = trap_step(v, prev_pt, x, dt20 - n * lag_t1, 20 * lag_t1);
        end
        lag_prev_in = x;
        lag_last_t = ts;
        return lag_v;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch: %s got %0d expected %0d", what, got, want);
        mismatch_count++;
    endtask

    // predict at acceptance so ordering follows the handshake
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready)
            filtered_q.push_back(lag_update(in_ch.sample, in_ch.time_stamp));
    end

    always @(posedge i_clk) begin
        logic signed [VW-1:0] want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            result_count++;
            if (filtered_q.size() == 0) begin
                report_mismatch("unexpected filtered item", out_ch.filtered, 0);
            end else begin
                want = filtered_q.pop_front();
                if (out_ch.filtered !== want)
                    report_mismatch("filtered", out_ch.filtered, want);
            end
        end
    end

    // receiver: random stalls, plus long hold-off when requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            out_ch.ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            out_ch.ready <= recv_stall_en ? ($urandom_range(99) >= 30) : 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [CIW-1:0] idx, logic [VW-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_T1:   lag_t1 = longint'(val[T1W-1:0]);
            CFG_GAIN: lag_k = longint'($signed(val));
            CFG_BIAS: lag_bias = longint'($signed(val));
            default:  ;
        endcase
    endtask

    task automatic drain();
        while (filtered_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_config(int unsigned t1, logic [31:0] k, logic [31:0] b);
        drain();
        write_reg(CFG_T1, t1);
        write_reg(CFG_GAIN, k);
        write_reg(CFG_BIAS, b);
    endtask

    // hold valid until the item is taken, then drop it
    task automatic send_sample(logic [31:0] smp, logic [TW-1:0] ts);
        if (send_stall_en)
            while ($urandom_range(99) < 30) @(posedge i_clk);
        in_ch.valid      <= 1'b1;
        in_ch.sample     <= smp;
        in_ch.time_stamp <= ts;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        in_ch.valid <= 1'b0;
        stamp_now = ts;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(3)
                                           : 32'h80000000 + $urandom_range(3);
            default: return 32'($signed($urandom_range(0, 20 * 65536)) - 10 * 65536);
        endcase
    endfunction

    // elapsed ticks chosen around the three regimes of the current T1
    function automatic logic [TW-1:0] rand_step();
        int unsigned t1;
        t1 = 32'(lag_t1);
        if (t1 == 0) return $urandom_range(50);
        case ($urandom_range(9))
            0: return 0;
            1: return $urandom_range(t1 / 20);
            2: return 5 * t1 + $urandom_range(3);
            3: return 32'hffff_fff0; // wraps backwards
            default: return $urandom_range(t1 / 20 + 1, t1 * 5 - 1);
        endcase
    endfunction

    task automatic test_directed();
        set_config(0, 32'h0001_0000, 0);
        send_sample(32'h7fffffff, 0);
        send_sample(32'h80000000, 1);
        send_sample(32'h0001_8000, 1);
        set_config(0, 32'h7fffffff, 32'h7fffffff);
        send_sample(32'h7fffffff, 2);
        send_sample(32'h80000000, 3);
        set_config(100, 32'h8000_0000, 32'h8000_0000);
        send_sample(32'h80000000, 3);
        send_sample(32'h0000_0001, 500);      // substeps
        set_config(100, 32'h0002_0000, 32'h0000_8000);
        send_sample(32'h0005_0000, 505);      // single step
        send_sample(32'h0005_0000, 505);      // equal stamps
        send_sample(32'h0007_0000, 510);      // single step
        send_sample(32'hfff0_0000, 511);      // single step
        send_sample(32'h0010_0000, 540);      // substeps
        send_sample(32'h0000_0000, 999);      // substeps near the jump edge
        send_sample(32'h0003_0000, 10);       // stamps going backwards
        set_config(3, 32'hffff_0000, 32'h7fff_0000);
        send_sample(32'h0001_0000, 12);
        send_sample(32'hffff_ffff, 14);
        set_config(24'hffffff, 32'h0001_0000, 0);
        send_sample(32'h0100_0000, 32'hffffffff); // jump from far
        send_sample(32'h0000_0000, 32'hffffffff);
        send_sample(32'h0010_0000, 32'h0000_0000 + 1000); // wrap, single step
    endtask

    task automatic test_random(int count, bit stalls);
        logic [TW-1:0] ts;
        send_stall_en = stalls;
        recv_stall_en = stalls;
        for (int i = 0; i < count; i++) begin
            ts = stamp_now + rand_step();
            send_sample(rand_value(), ts);
        end
    endtask

    task automatic test_backpressure();
        drain();
        hold_off_cycles = 400;
        test_random(6, 1'b0);
        drain();  // sender pauses until every result is in
        test_random(4, 1'b1);
    endtask

    initial begin
        int unsigned t1_pick;
        lag_t1 = 0; lag_k = 65536; lag_bias = 0;
        lag_v = 0; lag_prev_in = 0; lag_last_t = 0;
        mismatch_count = 0; result_count = 0; cycle_count = 0;
        send_stall_en = 0; recv_stall_en = 0; hold_off_cycles = 0;
        stamp_now = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0; i_cfg_idx = CFG_T1; i_cfg_data = '0;
        in_ch.valid = 1'b0; in_ch.sample = '0; in_ch.time_stamp = '0;
        out_ch.ready = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        for (int phase = 0; phase < 12; phase++) begin
            case (phase % 4)
                0: t1_pick = 0;
                1: t1_pick = $urandom_range(1, 40);
                2: t1_pick = $urandom_range(41, 2000);
                default: t1_pick = phase == 11 ? 24'hffffff : $urandom_range(24'hffffff);
            endcase
            set_config(t1_pick, rand_value(), $urandom_range(1) ? rand_value() : 0);
            test_random(120, phase != 4);
        end
        drain();
        repeat (600) @(posedge i_clk);

        $display("covered bypass, jump, single-step and substep updates with wrapped stamps,");
        $display("saturating gain/bias and back-pressure; %0d results checked", result_count);
        if (mismatch_count == 0 && filtered_q.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("%0d mismatches, %0d items outstanding", mismatch_count,
                     filtered_q.size());
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule

/* files.f */
hdl/folv_pkg.sv
hdl/folv_stream_if.sv
hdl/first_order_lag_variable_step_core.sv
verif/testbench.sv
